@@ hw/rtl/tpt_pkg.sv @@
`default_nettype none

package tpt_pkg;

    localparam int ADDR_W       = 16;
    localparam int OFFSET_BITS  = 8;
    localparam int PAGE_W       = ADDR_W - OFFSET_BITS;
    localparam int FRAME_W      = 8;

    localparam int TLB_ENTRIES  = 16;
    localparam int TLB_IDX_W    = $clog2(TLB_ENTRIES);

    localparam int LIST_ENTRIES = 256;
    localparam int LIST_IDX_W   = $clog2(LIST_ENTRIES);
    localparam int LIST_CNT_W   = $clog2(LIST_ENTRIES + 1);

    localparam int NUM_FRAMES   = 256;

    typedef logic [PAGE_W-1:0]     page_t;
    typedef logic [FRAME_W-1:0]    frame_t;
    typedef logic [TLB_IDX_W-1:0]  tlb_idx_t;
    typedef logic [LIST_IDX_W-1:0] list_idx_t;
    typedef logic [LIST_CNT_W-1:0] list_cnt_t;

    typedef struct packed {
        page_t  page;
        frame_t frame;
    } entry_t;

    typedef struct packed {
        logic   en;
        entry_t entry;
    } tlb_wr_t;

    typedef struct packed {
        logic      rd_en;
        list_idx_t rd_addr;
        logic      wr_en;
        list_idx_t wr_addr;
        entry_t    wr_entry;
        logic      fill_inc;
    } list_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tlb_page_table_translator_core.sv @@
`default_nettype none
// TLB hit: the TLB slots are compared in order from slot 0 until one matches.
// TLB miss: the list memory is then walked from its front entry; the time taken is set by the
// single comparator stepping the 16 TLB slots and then the list memory one entry a cycle.
// One item at a time: s_ready returns the cycle after the result transfer.
// Reset clears TLB valid bits, FIFO slot pointer, list fill count and frame counter;
// no clearing pass, the block is ready straight after reset.

module tlb_page_table_translator_core
    import tpt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ADDR_W-1:0] s_logical_address,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [ADDR_W-1:0]      m_physical_address,
    output logic                   m_tlb_hit,
    output logic                   m_page_fault
);

    typedef enum logic [2:0] {
        IDLE,
        TLB_SCAN,
        LIST_START,
        LIST_WALK,
        LIST_FRONT,
        RESULT
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] la_reg, la_next;
    tlb_idx_t          tidx_reg, tidx_next;
    list_idx_t         lidx_reg, lidx_next;
    entry_t            carry_reg, carry_next;
    frame_t            frame_reg, frame_next;
    frame_t            nff_reg, nff_next;
    logic              hit_reg, hit_next;
    logic              fault_reg, fault_next;

    logic      tlb_rd_valid;
    entry_t    tlb_rd_entry;
    tlb_wr_t   tlb_wr;
    list_ctl_t list_ctl;
    entry_t    list_rd_entry;
    list_cnt_t list_fill;

    page_t     page;
    logic      list_valid;
    logic      cmp_valid;
    entry_t    cmp_entry;
    logic      match;
    frame_t    nff_inc;

    tpt_tlb u_tlb (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_idx   (tidx_reg),
        .rd_valid (tlb_rd_valid),
        .rd_entry (tlb_rd_entry),
        .wr       (tlb_wr)
    );

    tpt_list u_list (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (list_ctl),
        .rd_entry (list_rd_entry),
        .fill     (list_fill)
    );

    assign page       = la_reg[ADDR_W-1:OFFSET_BITS];
    assign list_valid = LIST_CNT_W'(lidx_reg) < list_fill;

    always_comb begin
        if (state_reg == TLB_SCAN) begin
            cmp_valid = tlb_rd_valid;
            cmp_entry = tlb_rd_entry;
        end else begin
            cmp_valid = list_valid;
            cmp_entry = list_rd_entry;
        end
    end

    assign match = cmp_valid && (cmp_entry.page == page);

    always_comb begin
        if (nff_reg == FRAME_W'(NUM_FRAMES - 1)) begin
            nff_inc = '0;
        end else begin
            nff_inc = nff_reg + 1'b1;
        end
    end

    always_comb begin
        state_next = state_reg;
        la_next    = la_reg;
        tidx_next  = tidx_reg;
        lidx_next  = lidx_reg;
        carry_next = carry_reg;
        frame_next = frame_reg;
        nff_next   = nff_reg;
        hit_next   = hit_reg;
        fault_next = fault_reg;

        tlb_wr.en       = 1'b0;
        tlb_wr.entry    = '{page: page, frame: frame_reg};
        list_ctl.rd_en    = 1'b0;
        list_ctl.rd_addr  = lidx_reg + 1'b1;
        list_ctl.wr_en    = 1'b0;
        list_ctl.wr_addr  = lidx_reg;
        list_ctl.wr_entry = carry_reg;
        list_ctl.fill_inc = 1'b0;

        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    la_next    = s_logical_address;
                    tidx_next  = '0;
                    hit_next   = 1'b0;
                    fault_next = 1'b0;
                    state_next = TLB_SCAN;
                end
            end
            TLB_SCAN: begin
                if (match) begin
                    frame_next = tlb_rd_entry.frame;
                    hit_next   = 1'b1;
                    state_next = RESULT;
                end else if (tidx_reg == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
                    state_next = LIST_START;
                end else begin
                    tidx_next = tidx_reg + 1'b1;
                end
            end
            LIST_START: begin
                list_ctl.rd_en   = 1'b1;
                list_ctl.rd_addr = '0;
                lidx_next        = '0;
                state_next       = LIST_WALK;
            end
            LIST_WALK: begin
                list_ctl.wr_en = (lidx_reg != '0);
                if (match) begin
                    frame_next = list_rd_entry.frame;
                    state_next = LIST_FRONT;
                end else if (!list_valid) begin
                    frame_next        = nff_reg;
                    nff_next          = nff_inc;
                    fault_next        = 1'b1;
                    list_ctl.fill_inc = 1'b1;
                    state_next        = LIST_FRONT;
                end else if (lidx_reg == LIST_IDX_W'(LIST_ENTRIES - 1)) begin
                    frame_next = nff_reg;
                    nff_next   = nff_inc;
                    fault_next = 1'b1;
                    state_next = LIST_FRONT;
                end else begin
                    carry_next     = list_rd_entry;
                    lidx_next      = lidx_reg + 1'b1;
                    list_ctl.rd_en = 1'b1;
                end
            end
            LIST_FRONT: begin
                list_ctl.wr_en    = 1'b1;
                list_ctl.wr_addr  = '0;
                list_ctl.wr_entry = '{page: page, frame: frame_reg};
                tlb_wr.en         = 1'b1;
                state_next        = RESULT;
            end
            RESULT: begin
                if (m_ready) begin
                    state_next = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            nff_reg   <= '0;
        end else begin
            state_reg <= state_next;
            nff_reg   <= nff_next;
        end
        la_reg    <= la_next;
        tidx_reg  <= tidx_next;
        lidx_reg  <= lidx_next;
        carry_reg <= carry_next;
        frame_reg <= frame_next;
        hit_reg   <= hit_next;
        fault_reg <= fault_next;
    end

    assign s_ready            = (state_reg == IDLE);
    assign m_valid            = (state_reg == RESULT);
    assign m_physical_address = {frame_reg, la_reg[OFFSET_BITS-1:0]};
    assign m_tlb_hit          = hit_reg;
    assign m_page_fault       = fault_reg;

`ifndef ASSERT_OFF
    a_hit_fault_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_tlb_hit && m_page_fault))
        else $error("tlb hit and page fault flagged together");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        list_fill <= LIST_CNT_W'(LIST_ENTRIES))
        else $error("page list fill count overflow");

    a_front_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == LIST_FRONT) |=> m_valid && !m_tlb_hit)
        else $error("list miss path produced no result or a tlb hit");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/tpt_tlb.sv @@
`default_nettype none

module tpt_tlb
    import tpt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire tlb_idx_t rd_idx,
    output logic         rd_valid,
    output entry_t       rd_entry,
    input  wire tlb_wr_t wr
);

    entry_t                 entry_reg [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] valid_reg;
    tlb_idx_t               slot_reg;
    tlb_idx_t               slot_next;

    assign rd_valid = valid_reg[rd_idx];
    assign rd_entry = entry_reg[rd_idx];

    always_comb begin
        if (slot_reg == TLB_IDX_W'(TLB_ENTRIES - 1)) begin
            slot_next = '0;
        end else begin
            slot_next = slot_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end else if (wr.en) begin
            valid_reg[slot_reg] <= 1'b1;
            slot_reg            <= slot_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entry_reg[slot_reg] <= wr.entry;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tpt_list.sv @@
`default_nettype none

module tpt_list
    import tpt_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire list_ctl_t ctl,
    output entry_t         rd_entry,
    output list_cnt_t      fill
);

    entry_t    mem [LIST_ENTRIES];
    entry_t    rd_reg;
    list_cnt_t fill_reg;

    assign rd_entry = rd_reg;
    assign fill     = fill_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[ctl.wr_addr] <= ctl.wr_entry;
        end
        if (ctl.rd_en) begin
            rd_reg <= mem[ctl.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (ctl.fill_inc) begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire
